// File: rtl/core/two_class_pair_matcher_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-class pair matcher
// Concurrent assertion wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PAIR_MATCHER_CORE_ASSERT_SVH
`define TWO_CLASS_PAIR_MATCHER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define TCPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The condition must never be true outside reset.
`define TCPM_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`else

`define TCPM_ASSERT(label, prop, msg)
`define TCPM_NEVER(label, cond, msg)

`endif

`endif

// File: rtl/core/tcpm_pkg.sv
// ----------------------------------------------------------------------------
// Two-class pair matcher package
// Sizes, outcome codes and ring pointer helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpm_pkg;

    localparam int RING_SLOTS = 8;
    localparam int ID_BITS    = 16;
    localparam int PTR_BITS   = $clog2(RING_SLOTS);
    localparam int ADDR_BITS  = $clog2(2 * RING_SLOTS);

    localparam int IN_DATA_BITS  = ((ID_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((ID_BITS + 2 * PTR_BITS + 7) / 8) * 8;

    typedef logic [PTR_BITS-1:0]  t_ptr;
    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [1:0]           t_outcome;

    localparam t_outcome OUT_MATCHED  = 2'd0;
    localparam t_outcome OUT_QUEUED   = 2'd1;
    localparam t_outcome OUT_REJECTED = 2'd2;

    // Advance a ring pointer, wrapping at the last slot.
    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr q;
        if (p == PTR_BITS'(RING_SLOTS - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    // Number of waiters, (tail - head) modulo the ring size.
    function automatic t_ptr ring_count(input t_ptr head, input t_ptr tail);
        logic [PTR_BITS:0] diff;
        diff = {1'b0, tail} - {1'b0, head};
        if (tail < head) begin
            diff = diff + (PTR_BITS + 1)'(RING_SLOTS);
        end
        return diff[PTR_BITS-1:0];
    endfunction

    // Memory address of a slot: class 0 in the lower half, class 1 above it.
    function automatic t_addr slot_addr(input logic cls, input t_ptr p);
        t_addr a;
        a = ADDR_BITS'(p);
        if (cls) begin
            a = a + ADDR_BITS'(RING_SLOTS);
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/two_class_pair_matcher_core.sv
// A queued or rejected arrival sets the output register as it is taken; a matched arrival
// first waits in the read state for the ring memory read, and then sets it.
// Throughput: one arrival per cycle while arrivals queue or are rejected and the result
// stream does not stall; a match holds arrivals during its single-port synchronous read.
// Reset: synchronous, active low; all head and tail pointers return to zero, so both queues
// start empty. The ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Two-class pair matcher core
// Rendezvous matcher with one circular queue of waiters per class, both held
// in a single synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_pair_matcher_core_assert.svh"

module two_class_pair_matcher_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Arrival stream.
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // tdata, from bit 0: arrival_id.
    input  wire logic [tcpm_pkg::IN_DATA_BITS-1:0]      i_s_tdata,
    // tuser, from bit 0: arrival_class.
    input  wire logic                                   i_s_tuser,
    // Result stream.
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // tdata, from bit 0: partner_id, waiting_class0, waiting_class1, zero padding.
    output logic [tcpm_pkg::OUT_DATA_BITS-1:0]          o_m_tdata,
    // tuser, from bit 0: outcome.
    output logic [1:0]                                  o_m_tuser
);

    // The sequencer has two states: waiting for an arrival, and waiting for
    // the ring memory to return the partner of a matched arrival.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state, n_state;

    // Pointers live in flip-flops; only the identifiers live in memory.
    tcpm_pkg::t_ptr r_head0, n_head0;
    tcpm_pkg::t_ptr r_tail0, n_tail0;
    tcpm_pkg::t_ptr r_head1, n_head1;
    tcpm_pkg::t_ptr r_tail1, n_tail1;

    // Output register: it holds each result until the consumer takes it.
    logic                 r_out_valid, n_out_valid;
    tcpm_pkg::t_outcome   r_out_outcome, n_out_outcome;
    tcpm_pkg::t_id        r_out_partner, n_out_partner;
    tcpm_pkg::t_ptr       r_out_wait0, n_out_wait0;
    tcpm_pkg::t_ptr       r_out_wait1, n_out_wait1;

    // Ring memory, both classes, one access per cycle.
    tcpm_pkg::t_id  r_ring [0:2*tcpm_pkg::RING_SLOTS-1];
    tcpm_pkg::t_id  r_rd_data;
    logic           mem_wr_en;
    logic           mem_rd_en;
    tcpm_pkg::t_addr mem_addr;

    logic           in_take;
    logic           own_cls;
    tcpm_pkg::t_id  own_id;
    tcpm_pkg::t_ptr own_head, own_tail, other_head, other_tail;
    logic           other_empty;
    logic           own_full;

    // A new arrival is taken only while no read is in flight and the output
    // register is free, or is being emptied in this same cycle.
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign in_take    = i_s_tvalid && o_s_tready;

    assign own_cls = i_s_tuser;
    assign own_id  = i_s_tdata[tcpm_pkg::ID_BITS-1:0];

    assign own_head   = own_cls ? r_head1 : r_head0;
    assign own_tail   = own_cls ? r_tail1 : r_tail0;
    assign other_head = own_cls ? r_head0 : r_head1;
    assign other_tail = own_cls ? r_tail0 : r_tail1;

    assign other_empty = (other_head == other_tail);
    assign own_full    = (tcpm_pkg::ptr_next(own_tail) == own_head);

    always_comb begin
        n_state       = r_state;
        n_head0       = r_head0;
        n_tail0       = r_tail0;
        n_head1       = r_head1;
        n_tail1       = r_tail1;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_outcome = r_out_outcome;
        n_out_partner = r_out_partner;
        n_out_wait0   = r_out_wait0;
        n_out_wait1   = r_out_wait1;
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_addr      = tcpm_pkg::slot_addr(own_cls, tcpm_pkg::ptr_next(own_tail));

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (!other_empty) begin
                        // Pop the oldest waiter of the other class: the head
                        // moves on first, then the slot at the new head is read.
                        if (own_cls) begin
                            n_head0 = tcpm_pkg::ptr_next(r_head0);
                        end else begin
                            n_head1 = tcpm_pkg::ptr_next(r_head1);
                        end
                        mem_rd_en = 1'b1;
                        mem_addr  = tcpm_pkg::slot_addr(!own_cls,
                                                        tcpm_pkg::ptr_next(other_head));
                        n_state   = ST_READ;
                    end else if (own_full) begin
                        n_out_valid   = 1'b1;
                        n_out_outcome = tcpm_pkg::OUT_REJECTED;
                        n_out_partner = '0;
                    end else begin
                        // Join the own queue at the slot after the tail.
                        if (own_cls) begin
                            n_tail1 = tcpm_pkg::ptr_next(r_tail1);
                        end else begin
                            n_tail0 = tcpm_pkg::ptr_next(r_tail0);
                        end
                        mem_wr_en     = 1'b1;
                        n_out_valid   = 1'b1;
                        n_out_outcome = tcpm_pkg::OUT_QUEUED;
                        n_out_partner = '0;
                    end
                end
            end
            ST_READ: begin
                // The partner identifier is now in the read register.
                n_out_valid   = 1'b1;
                n_out_outcome = tcpm_pkg::OUT_MATCHED;
                n_out_partner = r_rd_data;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new result's waiting counts reflect the pointers after this step; a held result keeps its counts.
        if (n_out_valid && !(r_out_valid && !i_m_tready)) begin
            n_out_wait0 = tcpm_pkg::ring_count(n_head0, n_tail0);
            n_out_wait1 = tcpm_pkg::ring_count(n_head1, n_tail1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head0     <= '0;
            r_tail0     <= '0;
            r_head1     <= '0;
            r_tail1     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head0     <= n_head0;
            r_tail0     <= n_tail0;
            r_head1     <= n_head1;
            r_tail1     <= n_tail1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_outcome <= n_out_outcome;
        r_out_partner <= n_out_partner;
        r_out_wait0   <= n_out_wait0;
        r_out_wait1   <= n_out_wait1;
    end

    // Synchronous ring memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_ring[mem_addr] <= own_id;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_ring[mem_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_outcome;
    assign o_m_tdata  = tcpm_pkg::OUT_DATA_BITS'({r_out_wait1, r_out_wait0, r_out_partner});

    // A match always passes through the read state, waiting for the memory, before its result.
    `TCPM_ASSERT(a_match_reads, (in_take && !other_empty) |=> (r_state == ST_READ),
                 "matched arrival did not start a ring read")
    // An arrival queues only while the other class is empty.
    `TCPM_NEVER(a_one_side_waits, (r_head0 != r_tail0) && (r_head1 != r_tail1),
                "both classes hold waiters")
    // The read result always finds the output register free.
    `TCPM_NEVER(a_out_free_on_read, (r_state == ST_READ) && r_out_valid,
                "output register busy when partner read returned")
    // No arrival is taken while a read is in flight.
    `TCPM_NEVER(a_no_take_in_read, (r_state == ST_READ) && in_take,
                "arrival taken during a ring read")

endmodule

`default_nettype wire
